[rtl/core/fbct_pkg.sv]
package fbct_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;
    localparam int FOLD_SHIFT  = 16;
    localparam int BKT_W       = 16;   // widest bucket index the table supports

    localparam logic [2:0] ST_OPENED     = 3'd0;
    localparam logic [2:0] ST_ADDED      = 3'd1;
    localparam logic [2:0] ST_DONE       = 3'd2;
    localparam logic [2:0] ST_DONE_FIRST = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [31:0]      src_addr;
        logic [15:0]      src_port;
        logic [31:0]      dst_addr;
        logic [15:0]      dst_port;
        logic [31:0]      expected_total;
        logic [15:0]      segment_bytes;
        logic [BKT_W-1:0] bucket;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[rtl/core/fbct_front.sv]
module fbct_front import fbct_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_src_addr,
    input  logic [15:0] i_src_port,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_expected_total,
    input  logic [15:0] i_segment_bytes,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_item       o_item
);

    localparam int  IW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic        r_full;
    t_item       r_item;
    logic [15:0] r_k;
    logic [31:0] k32;
    logic        accept;
    logic        ready;
    logic [IW-1:0] bkt;

    assign k32    = i_src_addr ^ {16'd0, i_src_port} ^ i_dst_addr ^ {16'd0, i_dst_port};
    assign accept = start & ~r_full;
    assign busy   = r_full;
    assign o_push = ready & ~i_qstat.full;

    always_comb begin
        o_item        = r_item;
        o_item.bucket = BKT_W'(bkt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (o_push) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.src_addr       <= i_src_addr;
            r_item.src_port       <= i_src_port;
            r_item.dst_addr       <= i_dst_addr;
            r_item.dst_port       <= i_dst_port;
            r_item.expected_total <= i_expected_total;
            r_item.segment_bytes  <= i_segment_bytes;
            r_item.bucket         <= '0;
            r_k                   <= k32[15:0] ^ k32[31:FOLD_SHIFT];
        end
    end

    generate
        if (IS_POW2) begin : g_mask
            assign bkt   = r_k[IW-1:0];
            assign ready = r_full;
        end else begin : g_rem
            // reciprocal multiply, exact for a 16-bit key: quotient first, remainder next cycle
            localparam logic [31:0] RECIP =
                32'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

            logic [IW-1:0] r_rem;
            logic [15:0]   r_quo;
            logic [1:0]    r_ph;
            logic [47:0]   prod;
            logic [31:0]   quo_b;
            logic [15:0]   rem16;

            assign prod  = {16'd0, r_k} * {16'd0, RECIP};
            assign quo_b = {16'd0, r_quo} * 32'(BUCKETS);
            assign rem16 = r_k - quo_b[15:0];
            assign bkt   = r_rem;
            assign ready = r_full && (r_ph == 2'd0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ph <= 2'd0;
                end else if (accept) begin
                    r_ph <= 2'd2;
                end else if (r_ph != 2'd0) begin
                    r_ph <= r_ph - 2'd1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_ph == 2'd2) r_quo <= prod[47:32];
                if (r_ph == 2'd1) r_rem <= rem16[IW-1:0];
            end
        end
    endgenerate

endmodule

[rtl/core/fbct_queue.sv]
module fbct_queue import fbct_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qstat
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_item        = r_q[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_item;
    end

endmodule

[rtl/core/fbct_back.sv]
module fbct_back import fbct_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_qstat,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_byte_total,
    output logic [9:0]  o_bucket
);

    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_clr;
    t_item         r_cur;

    logic [WAYS-1:0] r_vld_mem [BUCKETS];
    logic [63:0]     r_adr_mem [WAYS][BUCKETS];
    logic [31:0]     r_prt_mem [WAYS][BUCKETS];
    logic [31:0]     r_tgt_mem [WAYS][BUCKETS];
    logic [31:0]     r_cnt_mem [WAYS][BUCKETS];

    logic [WAYS-1:0] r_vld_rd;
    logic [63:0]     r_adr_rd [WAYS];
    logic [31:0]     r_prt_rd [WAYS];
    logic [31:0]     r_tgt_rd [WAYS];
    logic [31:0]     r_cnt_rd [WAYS];

    logic [IW-1:0]   rd_idx, ex_idx, vld_wa;
    logic            vld_we;
    logic [WAYS-1:0] vld_wd;
    logic [WAYS-1:0] we_open, we_cnt;

    logic [WAYS-1:0] hit_v;
    logic            hit_any, free_any;
    logic [WW-1:0]   hit_w, free_w;
    logic [31:0]     cnt_sel, tgt_sel, sum_sat;
    logic [32:0]     sum;
    logic [63:0]     key_adr;
    logic [31:0]     key_prt;
    logic            first_done;
    logic            is_done;

    logic        n_done;
    logic [2:0]  n_status;
    logic [31:0] n_total;
    logic [WAYS-1:0] n_row;

    assign o_pop   = (r_state == S_IDLE) && !i_qstat.empty;
    assign rd_idx  = i_item.bucket[IW-1:0];
    assign ex_idx  = r_cur.bucket[IW-1:0];
    assign key_adr = {r_cur.src_addr, r_cur.dst_addr};
    assign key_prt = {r_cur.src_port, r_cur.dst_port};

    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_w    = '0;
        free_w   = '0;
        cnt_sel  = '0;
        tgt_sel  = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_v[w] = r_vld_rd[w] && (r_adr_rd[w] == key_adr) && (r_prt_rd[w] == key_prt);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_v[w]) begin
                hit_any = 1'b1;
                hit_w   = WW'(w);
                cnt_sel = r_cnt_rd[w];
                tgt_sel = r_tgt_rd[w];
            end
            if (!r_vld_rd[w]) begin
                free_any = 1'b1;
                free_w   = WW'(w);
            end
        end
    end

    assign sum        = {1'b0, cnt_sel} + {17'd0, r_cur.segment_bytes};
    assign sum_sat    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign is_done    = (sum_sat >= tgt_sel);
    assign first_done = (r_cur.segment_bytes != 16'd0) &&
                        ({16'd0, r_cur.segment_bytes} >= r_cur.expected_total);

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = ST_FULL;
        n_total  = '0;
        n_row    = r_vld_rd;
        we_open  = '0;
        we_cnt   = '0;
        vld_we   = 1'b0;
        vld_wa   = ex_idx;
        vld_wd   = '0;
        case (r_state)
            S_CLEAR: begin
                vld_we = 1'b1;
                vld_wa = r_clr;
                if (r_clr == IW'(BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_pop) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (hit_any) begin
                    n_total       = sum_sat;
                    we_cnt[hit_w] = 1'b1;
                    if (is_done) begin
                        n_status     = ST_DONE;
                        n_row[hit_w] = 1'b0;
                    end else begin
                        n_status = ST_ADDED;
                    end
                end else if (first_done) begin
                    n_status = ST_DONE_FIRST;
                    n_total  = {16'd0, r_cur.segment_bytes};
                end else if (free_any) begin
                    n_status        = ST_OPENED;
                    n_total         = {16'd0, r_cur.segment_bytes};
                    n_row[free_w]   = 1'b1;
                    we_open[free_w] = 1'b1;
                    we_cnt[free_w]  = 1'b1;
                end
                vld_we = 1'b1;
                vld_wd = n_row;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= n_done;
            if (r_state == S_CLEAR) r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_item;
        if (n_done) begin
            o_status     <= n_status;
            o_byte_total <= n_total;
            o_bucket     <= 10'(32'(ex_idx));
        end
    end

    // bucket row storage
    always_ff @(posedge i_clk) begin
        if (vld_we) r_vld_mem[vld_wa] <= vld_wd;
        if (o_pop)  r_vld_rd <= r_vld_mem[rd_idx];
        for (int w = 0; w < WAYS; w++) begin
            if (we_open[w]) begin
                r_adr_mem[w][ex_idx] <= key_adr;
                r_prt_mem[w][ex_idx] <= key_prt;
                r_tgt_mem[w][ex_idx] <= r_cur.expected_total;
            end
            if (we_cnt[w]) r_cnt_mem[w][ex_idx] <= n_total;
            if (o_pop) begin
                r_adr_rd[w] <= r_adr_mem[w][rd_idx];
                r_prt_rd[w] <= r_prt_mem[w][rd_idx];
                r_tgt_rd[w] <= r_tgt_mem[w][rd_idx];
                r_cnt_rd[w] <= r_cnt_mem[w][rd_idx];
            end
        end
    end

endmodule

[rtl/core/flow_byte_count_table_top.sv]
// channel   | ports                                          | beat
// ----------+------------------------------------------------+-------------------------
// segment   | start, busy, i_src_addr .. i_segment_bytes     | start & !busy
// result    | o_done, o_status, o_byte_total, o_bucket       | o_done, one cycle, no stall
//
// The back end reads the bucket row on the pop, then compares, updates and writes it back;
// it pops a new segment only from idle. Non power-of-two BUCKETS adds a quotient and a
// remainder register in the front end, which takes a new segment only once it has pushed.
// After reset the valid bits of every bucket are swept clear; segments queue meanwhile.
// busy is high the cycle after each beat and stays up until the segment is pushed, so
// also while the two-entry queue is full. Results leave in arrival order through the queue,
// the back-end bucket read registers and the o_done register.
module flow_byte_count_table_top import fbct_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_src_addr,
    input  logic [15:0] i_src_port,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_expected_total,
    input  logic [15:0] i_segment_bytes,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_byte_total,
    output logic [9:0]  o_bucket
);

    t_qstat qstat;
    t_item  push_item, pop_item;
    logic   push, pop;

    fbct_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_src_addr      (i_src_addr),
        .i_src_port      (i_src_port),
        .i_dst_addr      (i_dst_addr),
        .i_dst_port      (i_dst_port),
        .i_expected_total(i_expected_total),
        .i_segment_bytes (i_segment_bytes),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_item          (push_item)
    );

    fbct_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_item (pop_item),
        .o_qstat(qstat)
    );

    fbct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_item      (pop_item),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_byte_total(o_byte_total),
        .o_bucket    (o_bucket)
    );

endmodule

[sim/tb_flow_byte_count_table_top.sv]
module tb_flow_byte_count_table_top;
    import fbct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT = BUCKETS_DEF;
    localparam int NWAY = WAYS_DEF;
    localparam int N_RANDOM = 630;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic [31:0] sa;
        logic [15:0] sp;
        logic [31:0] da;
        logic [15:0] dp;
        logic [31:0] target;
        logic [15:0] nbytes;
        bit          typed;
        logic [2:0]  st;
        logic [31:0] tot;
    } t_seg;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] tot;
        logic [9:0]  bkt;
    } t_flow_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_src_addr;
    logic [15:0] i_src_port;
    logic [31:0] i_dst_addr;
    logic [15:0] i_dst_port;
    logic [31:0] i_expected_total;
    logic [15:0] i_segment_bytes;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_byte_total;
    logic [9:0]  o_bucket;

    // predictor copy of the table
    bit          tbl_valid [NBKT*NWAY];
    logic [63:0] tbl_addrs [NBKT*NWAY];
    logic [31:0] tbl_ports [NBKT*NWAY];
    logic [31:0] tbl_target[NBKT*NWAY];
    logic [31:0] tbl_count [NBKT*NWAY];

    t_flow_result pending_results[$];
    int  n_errors;
    int  n_beats;
    int  n_results;
    int  status_seen[5];
    longint cycle_cnt;

    flow_byte_count_table_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [9:0] flow_bucket(t_seg s);
        logic [31:0] k;
        k = s.sa ^ {16'h0, s.sp} ^ s.da ^ {16'h0, s.dp};
        k = (k ^ (k >> FOLD_SHIFT)) & 32'hFFFF;
        return 10'(k % NBKT);
    endfunction

    function automatic t_flow_result update_flow_table(t_seg s);
        t_flow_result r;
        int base, hit, free_w, e;
        logic [32:0] sum;
        r.bkt  = flow_bucket(s);
        base   = int'(r.bkt) * NWAY;
        hit    = -1;
        free_w = -1;
        for (int w = 0; w < NWAY; w++) begin
            e = base + w;
            if (tbl_valid[e]) begin
                if (hit < 0 && tbl_addrs[e] == {s.sa, s.da} && tbl_ports[e] == {s.sp, s.dp})
                    hit = w;
            end else if (free_w < 0) begin
                free_w = w;
            end
        end
        if (hit >= 0) begin
            e = base + hit;
            sum = {1'b0, tbl_count[e]} + 33'(s.nbytes);
            r.tot = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            tbl_count[e] = r.tot;
            if (r.tot >= tbl_target[e]) begin
                tbl_valid[e] = 1'b0;
                r.st = ST_DONE;
            end else begin
                r.st = ST_ADDED;
            end
        end else if (s.nbytes != 0 && 32'(s.nbytes) >= s.target) begin
            r.tot = 32'(s.nbytes);
            r.st  = ST_DONE_FIRST;
        end else if (free_w >= 0) begin
            e = base + free_w;
            tbl_valid[e]  = 1'b1;
            tbl_addrs[e]  = {s.sa, s.da};
            tbl_ports[e]  = {s.sp, s.dp};
            tbl_target[e] = s.target;
            tbl_count[e]  = 32'(s.nbytes);
            r.tot = 32'(s.nbytes);
            r.st  = ST_OPENED;
        end else begin
            r.tot = '0;
            r.st  = ST_FULL;
        end
        return r;
    endfunction

    // start stays high across a zero gap so it never takes two updates in one step
    task automatic send_segment(t_seg s);
        t_flow_result r;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_src_addr       <= s.sa;
        i_src_port       <= s.sp;
        i_dst_addr       <= s.da;
        i_dst_port       <= s.dp;
        i_expected_total <= s.target;
        i_segment_bytes  <= s.nbytes;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = update_flow_table(s);
        if (s.typed && (r.st !== s.st || r.tot !== s.tot)) begin
            $display("%0t: table row disagrees: exp st=%0d tot=%0d, predicted st=%0d tot=%0d",
                     $time, s.st, s.tot, r.st, r.tot);
            n_errors++;
        end
        if (s.typed) begin
            r.st  = s.st;
            r.tot = s.tot;
        end
        pending_results.push_back(r);
        n_beats++;
    endtask

    always @(posedge i_clk) begin
        t_flow_result x;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result st=%0d tot=%0d bkt=%0d",
                         $time, o_status, o_byte_total, o_bucket);
                n_errors++;
            end else begin
                x = pending_results.pop_front();
                if (o_status <= ST_FULL) status_seen[o_status]++;
                if (o_status !== x.st) begin
                    $display("%0t: status exp %0d got %0d", $time, x.st, o_status);
                    n_errors++;
                end
                if (o_byte_total !== x.tot) begin
                    $display("%0t: byte_total exp %0d got %0d", $time, x.tot, o_byte_total);
                    n_errors++;
                end
                if (o_bucket !== x.bkt) begin
                    $display("%0t: bucket exp %0d got %0d", $time, x.bkt, o_bucket);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_seg mk(logic [31:0] sa, logic [15:0] sp, logic [31:0] da,
                                logic [15:0] dp, logic [31:0] tg, logic [15:0] nb,
                                bit typed = 0, logic [2:0] st = ST_OPENED,
                                logic [31:0] tot = 0);
        t_seg s;
        s.sa = sa; s.sp = sp; s.da = da; s.dp = dp; s.target = tg; s.nbytes = nb;
        s.typed = typed; s.st = st; s.tot = tot;
        return s;
    endfunction

    // flow pool: small so that hits, completions and full buckets happen often
    t_seg flow_pool[$];

    function automatic t_seg random_flow_in_bucket(logic [9:0] b);
        t_seg s;
        logic [31:0] k;
        s = mk($urandom, 16'($urandom), $urandom, 16'($urandom), 0, 0);
        // force the fold to land on bucket b by adjusting dst_port
        k = s.sa ^ {16'h0, s.sp} ^ s.da ^ {16'h0, s.dp};
        k = (k ^ (k >> FOLD_SHIFT)) & 32'hFFFF;
        s.dp = s.dp ^ 16'(k[9:0] ^ b);
        return s;
    endfunction

    initial begin
        t_seg dir[$];
        t_seg s;
        t_seg f;
        int sel;
        cycle_cnt = 0;
        n_errors = 0; n_beats = 0; n_results = 0;
        start = 1'b0;
        i_src_addr = '0; i_src_port = '0; i_dst_addr = '0; i_dst_port = '0;
        i_expected_total = '0; i_segment_bytes = '0;
        for (int i = 0; i < NBKT*NWAY; i++) begin
            tbl_valid[i] = 1'b0;
        end
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        dir.push_back(mk(32'h0, 16'h0, 32'h0, 16'h0, 32'd100, 16'd10, 1, ST_OPENED, 32'd10));
        dir.push_back(mk(32'h0, 16'h0, 32'h0, 16'h0, 32'd100, 16'd20, 1, ST_ADDED, 32'd30));
        dir.push_back(mk(32'h0, 16'h0, 32'h0, 16'h0, 32'd100, 16'd70, 1, ST_DONE, 32'd100));
        dir.push_back(mk(32'hFFFF_FFFF, 16'hFFFF, 32'h1234_5678, 16'hFFFF, 32'd5, 16'd5,
                         1, ST_DONE_FIRST, 32'd5));
        dir.push_back(mk(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0,
                         1, ST_OPENED, 32'd0));
        dir.push_back(mk(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0,
                         1, ST_DONE, 32'd0));
        // saturation: big target, then many max segments later in random; here near-max
        dir.push_back(mk(32'hA5A5_0000, 16'h0001, 32'h5A5A_FFFF, 16'h8000, 32'hFFFF_FFFF,
                         16'hFFFF));
        dir.push_back(mk(32'hA5A5_0000, 16'h0001, 32'h5A5A_FFFF, 16'h8000, 32'h0, 16'hFFFF));
        for (int i = 0; i < 5; i++) begin
            f = random_flow_in_bucket(10'h3FF);
            f.target = 32'd1000; f.nbytes = 16'd1;
            f.typed = 1;
            f.st = (i < NWAY) ? ST_OPENED : ST_FULL;
            f.tot = (i < NWAY) ? 32'd1 : 32'd0;
            dir.push_back(f);
        end
        dir.push_back(mk(32'h0000_0001, 16'h0, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'h0));
        dir.push_back(mk(32'h0000_0001, 16'h0, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF));
        foreach (dir[i]) send_segment(dir[i]);

        // one flow with an all-ones target, hammered with max segments in the random run
        f = mk(32'hDEAD_BEEF, 16'h1F90, 32'h0A00_0001, 16'h0050, 32'hFFFF_FFFF, 16'hFFFF);
        f.nbytes = 16'h0;
        send_segment(f);

        for (int i = 0; i < 24; i++) begin
            flow_pool.push_back(random_flow_in_bucket(10'($urandom_range(0, 5))));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                s = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                s.target = ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(0, 3000));
                s.nbytes = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 600));
            end else if (sel == 8) begin
                s = mk($urandom, 16'($urandom), $urandom, 16'($urandom), $urandom,
                       16'($urandom));
            end else begin
                // hammer that flow with max segments
                s = f;
                s.nbytes = 16'hFFFF;
            end
            if ($urandom_range(0, 40) == 0) begin
                flow_pool[$urandom_range(0, flow_pool.size() - 1)] =
                    random_flow_in_bucket(10'($urandom));
            end
            s.typed = 0;
            send_segment(s);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d segments, checked %0d results", n_beats, n_results);
        $display("Statuses opened/added/done/first/full: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[flow_byte_count_table_top.f]
rtl/core/fbct_pkg.sv
rtl/core/fbct_front.sv
rtl/core/fbct_queue.sv
rtl/core/fbct_back.sv
rtl/core/flow_byte_count_table_top.sv
sim/tb_flow_byte_count_table_top.sv
